// File: hw/rtl/mbrw_pkg.sv
// shared types, codes and crc helper for the modbus rtu write-register master
`default_nettype none

package mbrw_pkg;

  // input mode codes
  localparam logic [1:0] MODE_SEND = 2'd0;
  localparam logic [1:0] MODE_RX   = 2'd1;
  localparam logic [1:0] MODE_GET  = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  // result kind codes
  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_HOST = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BUSY    = 2'd1;
  localparam logic [1:0] ST_CRC_ERR = 2'd2;

  // transaction phase codes
  localparam logic [1:0] PH_READY     = 2'd0;
  localparam logic [1:0] PH_RECEIVING = 2'd1;
  localparam logic [1:0] PH_DONE      = 2'd2;
  localparam logic [1:0] PH_CRC_ERR   = 2'd3;

  localparam logic [7:0]  FUNC_RESET = 8'd6;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  localparam int FRAME_LEN   = 8;
  localparam int CRC_BYTES   = 6;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [$clog2(FRAME_LEN)-1:0] frame_idx_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  dev_addr;
    logic [15:0] reg_addr;
    logic [15:0] reg_value;
    logic [7:0]  rx_byte;
  } cmd_t;

  // one bit step of the reflected crc-16/modbus
  function automatic logic [15:0] crc_step(input logic [15:0] c);
    logic [15:0] s;
    s = {1'b0, c[15:1]};
    if (c[0]) begin
      s = s ^ CRC_POLY;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mbrw_front.sv
// front stage: takes input transfers, drops meaningless modes, feeds the queue
`default_nettype none

module mbrw_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         mode,
  input  wire logic [7:0]         dev_addr,
  input  wire logic [15:0]        reg_addr,
  input  wire logic [15:0]        reg_value,
  input  wire logic [7:0]         rx_byte,
  output logic                    push_valid,
  input  wire logic               push_ready,
  output mbrw_pkg::cmd_t          push_cmd
);
  import mbrw_pkg::*;

  logic held;
  cmd_t cmd;

  assign in_ready   = !held || push_ready;
  assign push_valid = held;
  assign push_cmd   = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= (mode != MODE_NONE);
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd.mode      <= mode;
      cmd.dev_addr  <= dev_addr;
      cmd.reg_addr  <= reg_addr;
      cmd.reg_value <= reg_value;
      cmd.rx_byte   <= rx_byte;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mbrw_queue.sv
// short command queue between front and back
`default_nettype none

module mbrw_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  wire mbrw_pkg::cmd_t     push_cmd,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output mbrw_pkg::cmd_t          pop_cmd
);
  import mbrw_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mbrw_back.sv
// back end: transaction phase, frame store, bit-serial crc and result emission
`default_nettype none

module mbrw_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [7:0]         function_code,
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire mbrw_pkg::cmd_t     cmd,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    kind,
  output logic [7:0]              byte_value,
  output logic [1:0]              status,
  output logic                    last
);
  import mbrw_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CRC  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  localparam logic GOAL_SEND  = 1'b0;
  localparam logic GOAL_CHECK = 1'b1;

  localparam frame_idx_t LAST_IDX     = frame_idx_t'(FRAME_LEN - 1);
  localparam frame_idx_t LAST_CRC_IDX = frame_idx_t'(CRC_BYTES - 1);

  logic [1:0]  state;
  logic [1:0]  phase;
  frame_idx_t  byte_index;
  frame_idx_t  emit_idx;
  logic        emit_kind;
  logic        crc_goal;
  logic [15:0] crc;
  frame_idx_t  crc_byte;
  logic [2:0]  crc_bit;
  logic [7:0]  frame_store [FRAME_LEN];

  logic        out_free;
  logic        pop;
  logic        out_load;
  logic [15:0] crc_in;
  logic [15:0] crc_next;

  assign out_free  = !out_valid || out_ready;
  assign cmd_ready = (state == S_IDLE) && out_free;
  assign pop       = cmd_valid && cmd_ready;

  // fold in the next frame byte at the first bit step of each byte
  always_comb begin
    crc_in = crc;
    if (crc_bit == '0) begin
      crc_in = crc ^ {8'h00, frame_store[crc_byte]};
    end
    crc_next = crc_step(crc_in);
  end

  // a new result enters the output register this cycle
  always_comb begin
    out_load = 1'b0;
    if (state == S_IDLE && pop) begin
      if (cmd.mode == MODE_SEND) begin
        out_load = (phase != PH_READY);
      end else if (cmd.mode == MODE_GET) begin
        out_load = (phase != PH_DONE);
      end
    end else if (state == S_EMIT) begin
      out_load = out_free;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_READY;
      byte_index <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            unique case (cmd.mode)
              MODE_SEND: begin
                if (phase != PH_READY) begin
                  kind       <= KIND_HOST;
                  byte_value <= 8'h00;
                  status     <= ST_BUSY;
                  last       <= 1'b1;
                end else begin
                  frame_store[0] <= cmd.dev_addr;
                  frame_store[1] <= function_code;
                  frame_store[2] <= cmd.reg_addr[15:8];
                  frame_store[3] <= cmd.reg_addr[7:0];
                  frame_store[4] <= cmd.reg_value[15:8];
                  frame_store[5] <= cmd.reg_value[7:0];
                  crc        <= CRC_INIT;
                  crc_byte   <= '0;
                  crc_bit    <= '0;
                  crc_goal   <= GOAL_SEND;
                  phase      <= PH_RECEIVING;
                  byte_index <= '0;
                  state      <= S_CRC;
                end
              end
              MODE_RX: begin
                if (phase == PH_RECEIVING) begin
                  frame_store[byte_index] <= cmd.rx_byte;
                  byte_index <= byte_index + 1'b1;
                  if (byte_index == LAST_IDX) begin
                    crc      <= CRC_INIT;
                    crc_byte <= '0;
                    crc_bit  <= '0;
                    crc_goal <= GOAL_CHECK;
                    state    <= S_CRC;
                  end
                end
              end
              MODE_GET: begin
                if (phase == PH_DONE) begin
                  phase     <= PH_READY;
                  emit_idx  <= '0;
                  emit_kind <= KIND_HOST;
                  state     <= S_EMIT;
                end else begin
                  kind       <= KIND_HOST;
                  byte_value <= 8'h00;
                  last       <= 1'b1;
                  if (phase == PH_CRC_ERR) begin
                    status <= ST_CRC_ERR;
                    phase  <= PH_READY;
                  end else begin
                    status <= ST_BUSY;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_CRC: begin
          crc     <= crc_next;
          crc_bit <= crc_bit + 1'b1;
          if (&crc_bit) begin
            crc_byte <= crc_byte + 1'b1;
            if (crc_byte == LAST_CRC_IDX) begin
              if (crc_goal == GOAL_SEND) begin
                frame_store[6] <= crc_next[7:0];
                frame_store[7] <= crc_next[15:8];
                emit_idx       <= '0;
                emit_kind      <= KIND_LINE;
                state          <= S_EMIT;
              end else begin
                phase <= ({frame_store[7], frame_store[6]} == crc_next) ?
                         PH_DONE : PH_CRC_ERR;
                state <= S_IDLE;
              end
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            kind       <= emit_kind;
            byte_value <= frame_store[emit_idx];
            status     <= ST_OK;
            last       <= (emit_idx == LAST_IDX);
            emit_idx   <= emit_idx + 1'b1;
            if (emit_idx == LAST_IDX) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/modbus_rtu_write_register_master_core.sv
// Modbus RTU single-register write master: top level. Input transfers are
// taken by a one-entry front register into a two-entry command queue, so the
// host can keep handing in items while the back end works or while a result
// waits on the output register. The back end runs one command at a time. A
// line byte or a refused request is handled in the idle state; an accepted
// send first runs a bit-serial CRC-16 over the six header bytes and then puts
// out the eight request bytes at up to one per cycle; the eighth reply byte
// starts the same CRC check before the next command is taken; a get
// of a good reply puts out eight bytes at up to one per cycle. The one-bit-per-
// cycle CRC unit sets the cost of a frame. function_code (reset 6) is written
// through cfg_wr_en/cfg_wr_data and is only to be changed while the block is idle.
`default_nettype none

module modbus_rtu_write_register_master_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [7:0]  dev_addr,
  input  wire logic [15:0] reg_addr,
  input  wire logic [15:0] reg_value,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic [7:0]       byte_value,
  output logic [1:0]       status,
  output logic             last
);
  import mbrw_pkg::*;

  logic [7:0] function_code;
  logic       push_valid;
  logic       push_ready;
  cmd_t       push_cmd;
  logic       pop_valid;
  logic       pop_ready;
  cmd_t       pop_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      function_code <= FUNC_RESET;
    end else if (cfg_wr_en) begin
      function_code <= cfg_wr_data;
    end
  end

  mbrw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .dev_addr   (dev_addr),
    .reg_addr   (reg_addr),
    .reg_value  (reg_value),
    .rx_byte    (rx_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  mbrw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  mbrw_back u_back (
    .clk           (clk),
    .rst           (rst),
    .function_code (function_code),
    .cmd_valid     (pop_valid),
    .cmd_ready     (pop_ready),
    .cmd           (pop_cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .byte_value    (byte_value),
    .status        (status),
    .last          (last)
  );

endmodule

`default_nettype wire

// File: hw/rtl/mbrw_checker.sv
// port-level checks for the modbus rtu write-register master, bound to the top
`default_nettype none

module mbrw_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       kind,
  input wire logic [7:0] byte_value,
  input wire logic [1:0] status,
  input wire logic       last
);
  import mbrw_pkg::*;

  // a stalled result transfer stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // no result transfer comes out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // line bytes always carry an ok status
  a_line_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_LINE |-> status == ST_OK)
    else $error("line byte with non-ok status");

  // status-only answers are single host items with a zero byte
  a_status_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |->
      last && kind == KIND_HOST && byte_value == 8'h00 &&
      (status == ST_BUSY || status == ST_CRC_ERR))
    else $error("malformed status answer");

endmodule

bind modbus_rtu_write_register_master_core mbrw_checker u_mbrw_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .kind       (kind),
  .byte_value (byte_value),
  .status     (status),
  .last       (last)
);

`default_nettype wire

// File: verif/testbench.sv
// self-checking testbench for the modbus rtu write-register master core
`timescale 1ns / 1ps

module testbench;
  import mbrw_pkg::*;

  localparam int PLAN_LEN      = 25;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 60;
  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PRINT_CAP     = 100;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
    logic [1:0] status;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  dev;
    logic [15:0] ra;
    logic [15:0] rv;
    logic [7:0]  rx;
    logic        echo;    // rx byte is the sent request byte xor rx
    logic        typed;   // expected result is given in the row
    result_t     want;
  } plan_row_t;

  localparam result_t HOST_BUSY = '{KIND_HOST, 8'h00, ST_BUSY, 1'b1};
  localparam result_t CRC_FAIL  = '{KIND_HOST, 8'h00, ST_CRC_ERR, 1'b1};
  localparam result_t NO_RES    = '{1'b0, 8'h00, 2'd0, 1'b0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = MODE_SEND;
  logic [7:0]  dev_addr = 8'h00;
  logic [15:0] reg_addr = 16'h0000;
  logic [15:0] reg_value = 16'h0000;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [7:0]  byte_value;
  logic [1:0]  status;
  logic        last;

  modbus_rtu_write_register_master_core u_dut (.*);

  // master state as the host sees it
  logic [1:0] link_phase = PH_READY;
  logic [7:0] frame_buf [8];
  logic [7:0] sent_req [8];
  logic [3:0] rx_count = 4'd0;
  logic [7:0] func_code = FUNC_RESET;

  result_t due_results [$];
  result_t want_res;
  bit      pend_typed = 1'b0;
  result_t pend_want = NO_RES;
  int      errors = 0;
  int      cycles = 0;

  plan_row_t plan [PLAN_LEN] = '{
    '{MODE_GET,  8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b1, HOST_BUSY},
    '{MODE_RX,   8'h00, 16'h0000, 16'h0000, 8'hA5, 1'b0, 1'b0, NO_RES},
    '{MODE_NONE, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, 1'b0, NO_RES},
    '{MODE_SEND, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, NO_RES},
    '{MODE_SEND, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, 1'b1, HOST_BUSY},
    '{MODE_GET,  8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b1, HOST_BUSY},
    '{MODE_RX,   8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, NO_RES},
    '{MODE_RX,   8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, NO_RES},
    '{MODE_RX,   8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, NO_RES},
    '{MODE_RX,   8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, NO_RES},
    '{MODE_RX,   8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, NO_RES},
    '{MODE_RX,   8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, NO_RES},
    '{MODE_RX,   8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, NO_RES},
    '{MODE_RX,   8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, NO_RES},
    '{MODE_GET,  8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, NO_RES},
    '{MODE_SEND, 8'hFF, 16'hFFFF, 16'hFFFF, 8'h00, 1'b0, 1'b0, NO_RES},
    '{MODE_RX,   8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, NO_RES},
    '{MODE_RX,   8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, NO_RES},
    '{MODE_RX,   8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, NO_RES},
    '{MODE_RX,   8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, NO_RES},
    '{MODE_RX,   8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, NO_RES},
    '{MODE_RX,   8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, NO_RES},
    '{MODE_RX,   8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0, NO_RES},
    // reply crc high byte inverted
    '{MODE_RX,   8'h00, 16'h0000, 16'h0000, 8'hFF, 1'b1, 1'b0, NO_RES},
    '{MODE_GET,  8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b1, CRC_FAIL}
  };

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic logic [15:0] crc16_modbus(input logic [47:0] hdr);
    logic [15:0] c;
    c = 16'hFFFF;
    for (int k = 0; k < 6; k++) begin
      c = c ^ {8'h00, hdr[47 - 8 * k -: 8]};
      for (int n = 0; n < 8; n++) begin
        c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
    end
    return c;
  endfunction

  function automatic void owe(input bit emit, input result_t r);
    if (emit) begin
      due_results.push_back(r);
    end
  endfunction

  // advance the master state by one accepted transfer and queue what it owes
  function automatic void step_master(input logic [1:0] m, input logic [7:0] dev,
                                      input logic [15:0] ra, input logic [15:0] rv,
                                      input logic [7:0] rxb, input bit emit);
    logic [15:0] crc;
    case (m)
      MODE_SEND: begin
        if (link_phase != PH_READY) begin
          owe(emit, HOST_BUSY);
        end else begin
          frame_buf[0] = dev;
          frame_buf[1] = func_code;
          frame_buf[2] = ra[15:8];
          frame_buf[3] = ra[7:0];
          frame_buf[4] = rv[15:8];
          frame_buf[5] = rv[7:0];
          crc = crc16_modbus({frame_buf[0], frame_buf[1], frame_buf[2],
                              frame_buf[3], frame_buf[4], frame_buf[5]});
          frame_buf[6] = crc[7:0];
          frame_buf[7] = crc[15:8];
          sent_req = frame_buf;
          link_phase = PH_RECEIVING;
          rx_count = 4'd0;
          for (int k = 0; k < 8; k++) begin
            owe(emit, '{KIND_LINE, frame_buf[k], ST_OK, k == 7});
          end
        end
      end
      MODE_RX: begin
        if (link_phase == PH_RECEIVING) begin
          frame_buf[rx_count[2:0]] = rxb;
          rx_count = rx_count + 4'd1;
          if (rx_count >= 4'd8) begin
            crc = crc16_modbus({frame_buf[0], frame_buf[1], frame_buf[2],
                                frame_buf[3], frame_buf[4], frame_buf[5]});
            link_phase = ({frame_buf[7], frame_buf[6]} == crc) ? PH_DONE : PH_CRC_ERR;
            rx_count = 4'd0;
          end
        end
      end
      MODE_GET: begin
        if (link_phase == PH_DONE) begin
          link_phase = PH_READY;
          for (int k = 0; k < 8; k++) begin
            owe(emit, '{KIND_HOST, frame_buf[k], ST_OK, k == 7});
          end
        end else if (link_phase == PH_CRC_ERR) begin
          link_phase = PH_READY;
          owe(emit, CRC_FAIL);
        end else begin
          owe(emit, HOST_BUSY);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < PRINT_CAP) begin
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result byte_value", byte_value, 0);
      end else begin
        want_res = due_results.pop_front();
        if (kind !== want_res.kind) report_mismatch("kind", kind, want_res.kind);
        if (byte_value !== want_res.byte_value) begin
          report_mismatch("byte_value", byte_value, want_res.byte_value);
        end
        if (status !== want_res.status) report_mismatch("status", status, want_res.status);
        if (last !== want_res.last) report_mismatch("last", last, want_res.last);
      end
    end
    if (!rst && in_valid && in_ready) begin
      step_master(mode, dev_addr, reg_addr, reg_value, rx_byte, !pend_typed);
      if (pend_typed) begin
        due_results.push_back(pend_want);
      end
    end
  end

  // result side: random stalls with calm stretches
  initial begin
    int stall;
    int stretch;
    bit calm;
    stretch = 0;
    calm = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (stretch == 0) begin
        calm = ($urandom_range(0, 2) == 0);
        stretch = $urandom_range(8, 40);
      end
      stretch--;
      stall = calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  int in_stretch = 0;
  bit in_calm = 1'b0;

  // one input transfer, starting and ending at a falling edge
  task automatic offer(input logic [1:0] m, input logic [7:0] dev, input logic [15:0] ra,
                       input logic [15:0] rv, input logic [7:0] rxb, input bit typed,
                       input result_t want);
    int gap;
    if (in_stretch == 0) begin
      in_calm = ($urandom_range(0, 2) == 0);
      in_stretch = $urandom_range(8, 40);
    end
    in_stretch--;
    gap = in_calm ? 0 : $urandom_range(0, 15);
    repeat (gap) @(negedge clk);
    mode = m;
    dev_addr = dev;
    reg_addr = ra;
    reg_value = rv;
    rx_byte = rxb;
    pend_typed = typed;
    pend_want = want;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // wait until every owed result is in, then give trailing line bytes time
  task automatic settle();
    while (due_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_function_code(input logic [7:0] v);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    func_code = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  initial begin
    int counted;
    int pick;
    logic [1:0] m;
    logic [7:0] rxb;
    logic [7:0] fc;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < PLAN_LEN; i++) begin
      rxb = plan[i].echo ? (sent_req[rx_count[2:0]] ^ plan[i].rx) : plan[i].rx;
      offer(plan[i].mode, plan[i].dev, plan[i].ra, plan[i].rv, rxb,
            plan[i].typed, plan[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      fc = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      set_function_code(fc);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        // mostly well-formed transactions, the rest noise
        if (link_phase == PH_READY && pick < 80) begin
          m = MODE_SEND;
        end else if (link_phase == PH_RECEIVING && pick < 88) begin
          m = MODE_RX;
        end else if ((link_phase == PH_DONE || link_phase == PH_CRC_ERR) && pick < 80) begin
          m = MODE_GET;
        end else begin
          m = 2'($urandom_range(0, 3));
          pick = 100;
        end
        if (m == MODE_RX && link_phase == PH_RECEIVING && pick < 100) begin
          rxb = sent_req[rx_count[2:0]];
          if ($urandom_range(0, 19) == 0) rxb = rxb ^ 8'($urandom_range(1, 255));
        end else begin
          rxb = 8'($urandom_range(0, 255));
        end
        if (!(m == MODE_NONE || (m == MODE_RX && link_phase != PH_RECEIVING))) begin
          counted++;
        end
        offer(m, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), rxb, 1'b0, NO_RES);
      end
    end

    settle();
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
